FILE: hw/rtl/n2w_pkg.sv
// Shared types and constants for the spoken-number word generator.
// Holds word codes, digit and group counts, FSM state types and the BCD handoff word.
// No dependencies.
package n2w_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int GROUPS         = 4;
	localparam int DEC_DIGITS     = GROUPS * 3;
	localparam int WORD_W         = 5;
	localparam int MAX_WORDS      = 20;
	localparam int CNT_W          = 5;

	localparam logic [WORD_W-1:0] W_KHONG    = 5'd0;
	localparam logic [WORD_W-1:0] W_TRAM     = 5'd10;
	localparam logic [WORD_W-1:0] W_LE       = 5'd11;
	localparam logic [WORD_W-1:0] W_MUOI_ONE = 5'd12;
	localparam logic [WORD_W-1:0] W_MUOI     = 5'd13;
	localparam logic [WORD_W-1:0] W_LAM      = 5'd14;
	localparam logic [WORD_W-1:0] W_MOT_LOW  = 5'd15;
	localparam logic [WORD_W-1:0] W_NGAN     = 5'd16;

	// Slots of one spoken group, in speaking order
	localparam logic [2:0] SLOT_HUND  = 3'd0;
	localparam logic [2:0] SLOT_TRAM  = 3'd1;
	localparam logic [2:0] SLOT_TENS  = 3'd2;
	localparam logic [2:0] SLOT_MUOI  = 3'd3;
	localparam logic [2:0] SLOT_UNIT  = 3'd4;
	localparam logic [2:0] SLOT_SCALE = 3'd5;
	localparam int         SLOTS      = 6;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_SHIFT,
		CV_DONE
	} conv_state_t;

	typedef enum logic {
		SP_IDLE,
		SP_RUN
	} spk_state_t;

	typedef logic [GROUPS-1:0][2:0][3:0] dec_digits_t;

	// Converter to sequencer handoff
	typedef struct packed {
		logic        valid;
		dec_digits_t digits;
	} bcd_word_t;

endpackage

FILE: hw/rtl/n2w_bcd.sv
// Bit-serial binary to BCD converter (shift and add-three), one input bit per cycle.
// Depends on n2w_pkg.
module n2w_bcd import n2w_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	output bcd_word_t   bcd,
	input  logic        bcd_take
);

	localparam int BIT_CNT_W = $clog2(VALUE_BITS);

	conv_state_t            state_q, state_d;
	logic                   load, shift;
	logic [VALUE_BITS-1:0]  bin_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	dec_digits_t            bcd_q;
	logic [DEC_DIGITS-1:0][3:0] adj;
	logic [DEC_DIGITS-1:0][3:0] flat;
	logic [DEC_DIGITS*4-1:0]    adj_bits;

	assign flat     = bcd_q;
	assign adj_bits = adj;

	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			adj[i] = (flat[i] >= 4'd5) ? flat[i] + 4'd3 : flat[i];
		end
	end

	always_comb begin
		state_d  = state_q;
		load     = 1'b0;
		shift    = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			CV_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					load    = 1'b1;
					state_d = CV_SHIFT;
				end
			end
			CV_SHIFT: begin
				shift = 1'b1;
				if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
					state_d = CV_DONE;
				end
			end
			CV_DONE: begin
				if (bcd_take) begin
					state_d = CV_IDLE;
				end
			end
			default: state_d = CV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q     <= value[VALUE_BITS-1:0];
			bcd_q     <= '0;
			bit_cnt_q <= '0;
		end else if (shift) begin
			bin_q     <= bin_q << 1;
			bcd_q     <= {adj_bits[DEC_DIGITS*4-2:0], bin_q[VALUE_BITS-1]};
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end
	end

	assign bcd.valid  = (state_q == CV_DONE);
	assign bcd.digits = bcd_q;

endmodule

FILE: hw/rtl/n2w_speak.sv
// Word sequencer: walks the spoken groups of a BCD number, one word per cycle
// while out_stall is low, into an output register. Depends on n2w_pkg.
module n2w_speak import n2w_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bcd_word_t         bcd,
	output logic              bcd_take,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] word,
	output logic              last
);

	spk_state_t        state_q, state_d;
	dec_digits_t       digits_q;
	logic [1:0]        grp_q, top_q;
	logic [2:0]        slot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [GROUPS-1:0] nz_q;
	logic              out_valid_q, last_q;
	logic [WORD_W-1:0] word_q;

	logic              load, advance;
	logic [GROUPS-1:0] nz_in;
	logic [1:0]        top_in;
	logic [2:0]        first_slot;
	logic [3:0]        hund, tens, unit;
	logic              is_top, small_top;
	logic [SLOTS-1:0]  mask, rest;
	logic [2:0]        next_slot;
	logic [GROUPS-1:0] below;
	logic [1:0]        next_grp;
	logic              fin;
	logic [WORD_W-1:0] cur_word;

	// Incoming number: nonzero groups, top group and its first spoken slot
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			nz_in[g] = (bcd.digits[g] != '0);
		end
		top_in = 2'd0;
		for (int g = 1; g < GROUPS; g++) begin
			if (nz_in[g]) top_in = 2'(g);
		end
		if (bcd.digits[top_in][2] != 4'd0) begin
			first_slot = SLOT_HUND;
		end else if (bcd.digits[top_in][1] != 4'd0) begin
			first_slot = SLOT_TENS;
		end else begin
			first_slot = SLOT_UNIT;
		end
	end

	// Current group: which slots are spoken, and the word of this slot
	always_comb begin
		hund      = digits_q[grp_q][2];
		tens      = digits_q[grp_q][1];
		unit      = digits_q[grp_q][0];
		is_top    = (grp_q == top_q);
		small_top = is_top && (hund == 4'd0) && (tens == 4'd0);

		mask[SLOT_HUND]  = !small_top && ((hund != 4'd0) || !is_top);
		mask[SLOT_TRAM]  = mask[SLOT_HUND];
		mask[SLOT_TENS]  = !small_top && ((tens != 4'd0) || (unit != 4'd0));
		mask[SLOT_MUOI]  = !small_top && (tens >= 4'd2);
		mask[SLOT_UNIT]  = small_top || (unit != 4'd0);
		mask[SLOT_SCALE] = (grp_q != 2'd0);

		rest = mask & ~((SLOTS'(2) << slot_q) - SLOTS'(1));
		next_slot = slot_q;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (rest[i]) next_slot = 3'(i);
		end

		below = nz_q & ((GROUPS'(1) << grp_q) - GROUPS'(1));
		next_grp = 2'd0;
		for (int g = 0; g < GROUPS; g++) begin
			if (below[g]) next_grp = 2'(g);
		end

		fin = ((rest == '0) && (below == '0)) || (cnt_q == CNT_W'(MAX_WORDS - 1));

		case (slot_q)
			SLOT_HUND:  cur_word = {1'b0, hund};
			SLOT_TRAM:  cur_word = W_TRAM;
			SLOT_TENS: begin
				if (tens == 4'd0)      cur_word = W_LE;
				else if (tens == 4'd1) cur_word = W_MUOI_ONE;
				else                   cur_word = {1'b0, tens};
			end
			SLOT_MUOI:  cur_word = W_MUOI;
			SLOT_UNIT: begin
				if (!small_top && (tens >= 4'd2) && (unit == 4'd1))   cur_word = W_MOT_LOW;
				else if (!small_top && (tens != 4'd0) && (unit == 4'd5)) cur_word = W_LAM;
				else                                                  cur_word = {1'b0, unit};
			end
			SLOT_SCALE: cur_word = W_NGAN + {3'b000, grp_q} - 5'd1;
			default:    cur_word = W_KHONG;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		load     = 1'b0;
		advance  = 1'b0;
		bcd_take = 1'b0;
		case (state_q)
			SP_IDLE: begin
				bcd_take = bcd.valid;
				if (bcd.valid) begin
					load    = 1'b1;
					state_d = SP_RUN;
				end
			end
			SP_RUN: begin
				advance = !out_valid_q || !out_stall;
				if (advance && fin) begin
					state_d = SP_IDLE;
				end
			end
			default: state_d = SP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= bcd.digits;
			nz_q     <= nz_in;
			top_q    <= top_in;
			grp_q    <= top_in;
			slot_q   <= first_slot;
			cnt_q    <= '0;
		end else if (advance) begin
			word_q <= cur_word;
			last_q <= fin;
			cnt_q  <= cnt_q + 1'b1;
			if (rest != '0) begin
				slot_q <= next_slot;
			end else begin
				grp_q  <= next_grp;
				slot_q <= SLOT_HUND;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign word      = word_q;
	assign last      = last_q;

endmodule

FILE: hw/rtl/number_to_spoken_word_tokens_top.sv
// Spoken Vietnamese number words: one unsigned number in, a run of word codes out.
// Input channel: in_valid / in_stall carry one 32-bit value; a word is taken at a
//   clock edge where in_valid is high and in_stall is low. Only the low VALUE_BITS
//   bits count.
// Output channel: out_valid / out_stall carry word (5-bit code) and last, which
//   marks the final word of each number's run. Zero gives the single word KHONG.
// Flow: the value is loaded, converted bit-serially from binary to BCD, handed
//   to the sequencer, and then the first word lands in the output register;
//   further words follow one per cycle while out_stall is low.
// Overlap: the converter is free again once its result is handed to the
//   sequencer, so it can take a new value while the sequencer still speaks the
//   last one. A run holds at most MAX_WORDS (20) words, so without output stalls
//   the serial shift-and-add-three loop, not the sequencer, limits how often a
//   new value is taken.
// Stall: a stalled output word holds; the sequencer waits, and the converter
//   holds its finished result and raises in_stall until the sequencer takes it.
// Reset (arst_n low, asynchronous): both FSMs return to idle and the output
//   register empties; payload registers are not cleared.
// Depends on n2w_pkg, n2w_bcd and n2w_speak.
module number_to_spoken_word_tokens_top import n2w_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] word,
	output logic              last
);

	bcd_word_t bcd;
	logic      bcd_take;

	// Serial binary to decimal digits
	n2w_bcd #(
		.VALUE_BITS(VALUE_BITS)
	) u_bcd (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.bcd      (bcd),
		.bcd_take (bcd_take)
	);

	// Group walk and word output register
	n2w_speak u_speak (
		.clk       (clk),
		.arst_n    (arst_n),
		.bcd       (bcd),
		.bcd_take  (bcd_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.word      (word),
		.last      (last)
	);

endmodule
